// ===== hdl/assert_macros.svh =====
// Assertion helper macros used by the rhc_checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, masked while reset is high.
`define ASSERT_CLK(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) \
    else $error("assertion failed");

// Clocked implication, masked while reset is high.
`define ASSERT_IMPL(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("implication failed");

`endif

// ===== hdl/rhc_pkg.sv =====
// ----------------------------------------------------------------------------
// rhc_pkg
// Shared widths and pipeline payload types of the RGB to HSV converter.
// ----------------------------------------------------------------------------
package rhc_pkg;

  localparam int SAMPLE_BITS = 10;
  localparam int SUM_W       = SAMPLE_BITS + 2;
  localparam int QW          = 12;                 // quotient bits, one per cell
  localparam int HUE_NW      = SAMPLE_BITS + 12;   // hue numerator < 3600*d
  localparam int DIV_W       = SAMPLE_BITS + 21;   // remainder/divisor width
  localparam int NLANE       = 3;

  localparam int LANE_HUE = 0;
  localparam int LANE_SAT = 1;
  localparam int LANE_VAL = 2;

  typedef struct packed {
    logic [DIV_W-1:0] rem;
    logic [DIV_W-1:0] dvs;
    logic [QW-1:0]    q;
  } lane_t;

  typedef struct packed {
    logic                   valid;
    lane_t [NLANE-1:0]      lane;
  } stage_t;

endpackage

// ===== hdl/rgb_to_hsv_converter.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter
// Raw RGB to HSV in tenths, one sample per clock unless out_stall holds it.
// ----------------------------------------------------------------------------
// Takes one sample per clock while not stalled, through 13 register stages:
// one setup stage (max/min, sector, dividends) followed by a chain of 12
// divider cells, each producing one quotient bit of the hue, saturation and
// value quotients. A result passes the setup register, then each cell in
// turn; the last cell is the output register. The whole chain holds while a
// result waits under out_stall, so in_stall follows out_stall only then.
module rgb_to_hsv_converter (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  logic [rhc_pkg::SAMPLE_BITS-1:0] red_sample,
  input  logic [rhc_pkg::SAMPLE_BITS-1:0] green_sample,
  input  logic [rhc_pkg::SAMPLE_BITS-1:0] blue_sample,
  output logic                            out_valid,
  input  logic                            out_stall,
  output logic [11:0]                     hue_tenths,
  output logic [9:0]                      saturation_tenths,
  output logic [9:0]                      value_tenths
);

  rhc_pkg::stage_t st [rhc_pkg::QW+1];
  logic en;

  assign en       = !(st[rhc_pkg::QW].valid && out_stall);
  assign in_stall = !en;

  rhc_front u_front (
    .clk(clk), .rst(rst), .en(en), .in_valid(in_valid),
    .r(red_sample), .g(green_sample), .b(blue_sample), .st(st[0])
  );

  for (genvar i = 0; i < rhc_pkg::QW; i++) begin : g_cell
    rhc_cell u_cell (
      .clk(clk), .rst(rst), .en(en), .din(st[i]), .dout(st[i+1])
    );
  end

  assign out_valid         = st[rhc_pkg::QW].valid;
  assign hue_tenths        = st[rhc_pkg::QW].lane[rhc_pkg::LANE_HUE].q[11:0];
  assign saturation_tenths = st[rhc_pkg::QW].lane[rhc_pkg::LANE_SAT].q[9:0];
  assign value_tenths      = st[rhc_pkg::QW].lane[rhc_pkg::LANE_VAL].q[9:0];

endmodule

// ===== hdl/rhc_front.sv =====
// ----------------------------------------------------------------------------
// rhc_front
// Max/min, sector select and dividend/divisor setup for the divider chain.
// ----------------------------------------------------------------------------
module rhc_front (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            en,
  input  logic                            in_valid,
  input  logic [rhc_pkg::SAMPLE_BITS-1:0] r,
  input  logic [rhc_pkg::SAMPLE_BITS-1:0] g,
  input  logic [rhc_pkg::SAMPLE_BITS-1:0] b,
  output rhc_pkg::stage_t                 st
);

  localparam int SW = rhc_pkg::SAMPLE_BITS;
  localparam int HW = rhc_pkg::HUE_NW;
  localparam int DW = rhc_pkg::DIV_W;

  logic [SW-1:0]  mx, mn, d, op_a, op_c;
  logic [rhc_pkg::SUM_W-1:0] sum;
  logic [HW-1:0]  base, wrap, dlt, hue_num;
  logic [DW-1:0]  hue_dvs, sat_dvs, val_dvs, sat_num, val_num;
  rhc_pkg::stage_t st_next;

  always_comb begin
    sum = rhc_pkg::SUM_W'(r) + rhc_pkg::SUM_W'(g) + rhc_pkg::SUM_W'(b);
    mx = r;
    if (g > mx) mx = g;
    if (b > mx) mx = b;
    mn = r;
    if (g < mn) mn = g;
    if (b < mn) mn = b;
    d = mx - mn;

    // sector: red wins ties, then green
    if (mx == r) begin
      op_a = g; op_c = b; base = '0;
    end else if (mx == g) begin
      op_a = b; op_c = r; base = HW'(d) * HW'(1200);
    end else begin
      op_a = r; op_c = g; base = HW'(d) * HW'(2400);
    end
    wrap = (mx == r) ? HW'(d) * HW'(3600) : base;
    if (op_a >= op_c) begin
      dlt = HW'(op_a - op_c) * HW'(600);
      hue_num = base + dlt;
    end else begin
      dlt = HW'(op_c - op_a) * HW'(600);
      hue_num = wrap - dlt;
    end

    sat_num = DW'(d) * DW'(1000);
    val_num = DW'(mx) * DW'(255000);

    // gray and all-zero samples divide zero by one
    if (d == '0) begin
      hue_num = '0;
      sat_num = '0;
      hue_dvs = DW'(1) << (rhc_pkg::QW - 1);
      sat_dvs = DW'(1) << (rhc_pkg::QW - 1);
    end else begin
      hue_dvs = DW'(d) << (rhc_pkg::QW - 1);
      sat_dvs = DW'(mx) << (rhc_pkg::QW - 1);
    end
    if (sum == '0) begin
      val_num = '0;
      val_dvs = DW'(1) << (rhc_pkg::QW - 1);
    end else begin
      val_dvs = (DW'(sum) << 8) << (rhc_pkg::QW - 1);
    end

    st_next.valid = in_valid;
    st_next.lane[rhc_pkg::LANE_HUE].rem = DW'(hue_num);
    st_next.lane[rhc_pkg::LANE_HUE].dvs = hue_dvs;
    st_next.lane[rhc_pkg::LANE_HUE].q   = '0;
    st_next.lane[rhc_pkg::LANE_SAT].rem = sat_num;
    st_next.lane[rhc_pkg::LANE_SAT].dvs = sat_dvs;
    st_next.lane[rhc_pkg::LANE_SAT].q   = '0;
    st_next.lane[rhc_pkg::LANE_VAL].rem = val_num;
    st_next.lane[rhc_pkg::LANE_VAL].dvs = val_dvs;
    st_next.lane[rhc_pkg::LANE_VAL].q   = '0;
  end

  always_ff @(posedge clk) begin
    if (en) st.lane <= st_next.lane;
    if (rst) st.valid <= 1'b0;
    else if (en) st.valid <= st_next.valid;
  end

endmodule

// ===== hdl/rhc_cell.sv =====
// ----------------------------------------------------------------------------
// rhc_cell
// One restoring-division step for all three lanes: one quotient bit each.
// ----------------------------------------------------------------------------
module rhc_cell (
  input  logic            clk,
  input  logic            rst,
  input  logic            en,
  input  rhc_pkg::stage_t din,
  output rhc_pkg::stage_t dout
);

  rhc_pkg::stage_t dout_next;

  always_comb begin
    dout_next = din;
    for (int i = 0; i < rhc_pkg::NLANE; i++) begin
      if (din.lane[i].rem >= din.lane[i].dvs) begin
        dout_next.lane[i].rem = din.lane[i].rem - din.lane[i].dvs;
        dout_next.lane[i].q   = {din.lane[i].q[rhc_pkg::QW-2:0], 1'b1};
      end else begin
        dout_next.lane[i].q   = {din.lane[i].q[rhc_pkg::QW-2:0], 1'b0};
      end
      dout_next.lane[i].dvs = din.lane[i].dvs >> 1;
    end
  end

  always_ff @(posedge clk) begin
    if (en) dout.lane <= dout_next.lane;
    if (rst) dout.valid <= 1'b0;
    else if (en) dout.valid <= dout_next.valid;
  end

endmodule

// ===== hdl/rhc_checker.sv =====
// ----------------------------------------------------------------------------
// rhc_checker
// Port-level checks of the RGB to HSV converter.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rhc_checker (
  input logic        clk,
  input logic        rst,
  input logic        in_stall,
  input logic        out_valid,
  input logic        out_stall,
  input logic [11:0] hue_tenths,
  input logic [9:0]  saturation_tenths,
  input logic [9:0]  value_tenths
);

  `ASSERT_CLK(a_out_hold, clk, rst, (out_valid && out_stall) |=> out_valid)
  `ASSERT_IMPL(a_stall_src, clk, rst, in_stall, out_valid && out_stall)
  `ASSERT_IMPL(a_hue_rng, clk, rst, out_valid, hue_tenths < 12'd3600)
  `ASSERT_IMPL(a_sat_rng, clk, rst, out_valid, saturation_tenths <= 10'd1000)
  `ASSERT_IMPL(a_val_rng, clk, rst, out_valid, value_tenths <= 10'd996)

endmodule

bind rgb_to_hsv_converter rhc_checker u_rhc_checker (
  .clk(clk), .rst(rst), .in_stall(in_stall), .out_valid(out_valid),
  .out_stall(out_stall), .hue_tenths(hue_tenths),
  .saturation_tenths(saturation_tenths), .value_tenths(value_tenths)
);

// ===== tb/rgb_to_hsv_converter_tb.sv =====
// ----------------------------------------------------------------------------
// rgb_to_hsv_converter_tb
// Drives RGB samples with random idle and stall bursts, predicts hue,
// saturation and value per sample and checks each result in order.
// ----------------------------------------------------------------------------
module rgb_to_hsv_converter_tb;

  localparam int SB = rhc_pkg::SAMPLE_BITS;

  typedef struct {
    logic [11:0] hue;
    logic [9:0]  sat;
    logic [9:0]  val;
  } hsv_t;

  class hsv_scoreboard;
    hsv_t pending[$];
    int   errors;

    function hsv_t convert(logic [SB-1:0] r, logic [SB-1:0] g,
                           logic [SB-1:0] b);
      longint rr, gg, bb, mx, mn, d, num, sum;
      hsv_t o;
      rr = r;
      gg = g;
      bb = b;
      sum = rr + gg + bb;
      mx = rr;
      if (gg > mx) mx = gg;
      if (bb > mx) mx = bb;
      mn = rr;
      if (gg < mn) mn = gg;
      if (bb < mn) mn = bb;
      d = mx - mn;
      o.hue = '0;
      o.sat = '0;
      o.val = '0;
      if (sum > 0) o.val = 10'((mx * 255000) / (256 * sum));
      if (d > 0) begin
        // red wins ties, then green
        if (mx == rr) num = 600 * (gg - bb);
        else if (mx == gg) num = 600 * (bb - rr) + 1200 * d;
        else num = 600 * (rr - gg) + 2400 * d;
        if (num < 0) num += 3600 * d;
        o.hue = 12'(num / d);
        o.sat = 10'((1000 * d) / mx);
      end
      return o;
    endfunction

    function void note_sample(logic [SB-1:0] r, logic [SB-1:0] g,
                              logic [SB-1:0] b);
      pending.push_back(convert(r, g, b));
    endfunction

    function void check_result(logic [11:0] h, logic [9:0] s, logic [9:0] v);
      hsv_t e;
      if (pending.size() == 0) begin
        $error("result with no sample pending: hue %0d sat %0d val %0d", h, s, v);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (h !== e.hue) begin
        $error("hue_tenths: expected %0d, actual %0d", e.hue, h);
        errors++;
      end
      if (s !== e.sat) begin
        $error("saturation_tenths: expected %0d, actual %0d", e.sat, s);
        errors++;
      end
      if (v !== e.val) begin
        $error("value_tenths: expected %0d, actual %0d", e.val, v);
        errors++;
      end
    endfunction
  endclass

  localparam int N_RANDOM = 1600;
  localparam int CALM_TAIL = 200;
  localparam int LIMIT = 200000;
  localparam int MAXV = (1 << SB) - 1;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic in_valid = 1'b0;
  logic in_stall;
  logic [SB-1:0] red_sample = '0, green_sample = '0, blue_sample = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic [11:0] hue_tenths;
  logic [9:0] saturation_tenths, value_tenths;

  hsv_scoreboard sb = new();
  int cycles = 0;
  bit calm = 1'b0;

  rgb_to_hsv_converter DUT (.*);

  always #4 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (!rst && in_valid && !in_stall)
      sb.note_sample(red_sample, green_sample, blue_sample);
    if (!rst && out_valid && !out_stall)
      sb.check_result(hue_tenths, saturation_tenths, value_tenths);
  end

  // receiver stall bursts
  initial begin
    int n;
    @(negedge clk);
    forever begin
      if (calm || $urandom_range(0, 3) != 0) begin
        out_stall <= 1'b0;
        @(negedge clk);
      end else begin
        n = $urandom_range(1, 11);
        out_stall <= 1'b1;
        repeat (n) @(negedge clk);
      end
    end
  end

  task automatic send(int r, int g, int b);
    int n;
    if (!calm && $urandom_range(0, 4) == 0) begin
      n = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (n) @(negedge clk);
    end
    in_valid <= 1'b1;
    red_sample <= SB'(r);
    green_sample <= SB'(g);
    blue_sample <= SB'(b);
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  function automatic int pick_chan();
    case ($urandom_range(0, 5))
      0: return 0;
      1: return MAXV;
      default: return $urandom_range(0, MAXV);
    endcase
  endfunction

  initial begin
    int r, g, b, c;
    repeat (7) @(negedge clk);
    rst <= 1'b0;
    @(negedge clk);
    // directed: zero, gray, extremes, ties, each sector and hue wrap
    send(0, 0, 0);
    send(MAXV, MAXV, MAXV);
    send(1, 1, 1);
    send(MAXV, 0, 0);
    send(0, MAXV, 0);
    send(0, 0, MAXV);
    send(MAXV, MAXV, 0);
    send(MAXV, 0, MAXV);
    send(0, MAXV, MAXV);
    send(MAXV, 1, 0);
    send(MAXV, 0, 1);
    send(1, MAXV, 0);
    send(0, MAXV, 1);
    send(1, 0, MAXV);
    send(0, 1, MAXV);
    send(MAXV, MAXV - 1, MAXV - 1);
    send(1, 0, 0);
    send(512, 256, 128);
    send(341, 682, 1023);
    send(1023, 1022, 1021);
    for (int i = 0; i < N_RANDOM; i++) begin
      if (i == N_RANDOM - CALM_TAIL) calm = 1'b1;
      c = $urandom_range(0, 9);
      if (c == 0) begin
        r = $urandom_range(0, MAXV);
        g = r;
        b = r;
      end else if (c == 1) begin
        r = $urandom_range(0, MAXV);
        g = r;
        b = $urandom_range(0, MAXV);
      end else begin
        r = pick_chan();
        g = pick_chan();
        b = pick_chan();
      end
      send(r, g, b);
    end
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (30) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("SCOREBOARD CLEAN");
    else
      $display("SCOREBOARD MISMATCH");
    $finish;
  end
endmodule
